// ===== sv/swsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scale weight stability detector package
// Shared types, character codes and scaling helpers.
// ----------------------------------------------------------------------------
package swsd_pkg;

  localparam int WEIGHT_W        = 38;
  localparam int MAG_W           = 37;
  localparam int POS_W           = 4;
  localparam int FRAC_W          = 2;
  localparam int DUR_W           = 16;
  localparam int FRACTION_DIGITS = 3;

  localparam logic [POS_W-1:0] RESPONSE_MIN_BYTES = 4'd10;
  localparam logic [POS_W-1:0] POS_MAX            = 4'd15;
  localparam logic [POS_W-1:0] POS_LAST_TEXT      = 4'd8;
  localparam logic [DUR_W-1:0] DUR_RESET          = 16'd1000;

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_POINT = 8'd46;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_TIMEOUT = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_WAIT    = 2'd0,
    ST_STABLE  = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_BADCHAR = 2'd3
  } status_e;

  typedef struct packed {
    logic                       short_resp;
    logic                       bad_char;
    logic signed [WEIGHT_W-1:0] reading;
  } parse_res_t;

  // A digit placed in front of the point, scaled to the full fraction.
  function automatic logic [MAG_W-1:0] int_digit(input logic [3:0] d);
    logic [MAG_W-1:0] w;
    w = MAG_W'(d);
    for (int i = 0; i < FRACTION_DIGITS; i++) begin
      w = MAG_W'(w * 10);
    end
    return w;
  endfunction

  // A fraction digit at position fc after the point.
  function automatic logic [MAG_W-1:0] frac_digit(input logic [3:0] d,
                                                  input logic [FRAC_W-1:0] fc);
    logic [MAG_W-1:0] w;
    w = MAG_W'(d);
    for (int i = 1; i < FRACTION_DIGITS; i++) begin
      if (i > int'(fc)) begin
        w = MAG_W'(w * 10);
      end
    end
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== sv/swsd_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style access to the stability duration register.
// ----------------------------------------------------------------------------
module swsd_regs
  import swsd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [1:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output logic      [DUR_W-1:0] duration_o
);

  logic [DUR_W-1:0] dur_q;
  logic [DUR_W-1:0] dur_d;
  logic             wr_en;

  // With a single register every word address selects it.
  assign wr_en = psel && penable && pwrite && (paddr[1:0] == paddr[1:0]);

  always_comb begin
    dur_d = dur_q;
    if (wr_en) begin
      dur_d = pwdata[DUR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q <= DUR_RESET;
    end else begin
      dur_q <= dur_d;
    end
  end

  assign prdata     = {{(32-DUR_W){1'b0}}, dur_q};
  assign pready     = 1'b1;
  assign duration_o = dur_q;

endmodule
`default_nettype wire

// ===== sv/swsd_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response parser
// Checks and converts the response text one byte at a time.
// ----------------------------------------------------------------------------
module swsd_parser
  import swsd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [1:0] cmd_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       eor_i,
  output parse_res_t      res_o
);

  logic [POS_W-1:0]  pos_q, pos_d, pos_t;
  logic              neg_q, neg_d, neg_t;
  logic [MAG_W-1:0]  mag_q, mag_d, mag_t;
  logic              point_q, point_d, point_t;
  logic [FRAC_W-1:0] frac_q, frac_d, frac_t;
  logic              stop_q, stop_d, stop_t;
  logic              bad_q, bad_d, bad_t;
  logic              is_digit;
  logic [3:0]        digit;

  assign is_digit = (rx_byte_i >= CHAR_ZERO) && (rx_byte_i <= CHAR_NINE);
  assign digit    = 4'(rx_byte_i - CHAR_ZERO);

  // Parser state after this byte.
  always_comb begin
    pos_t   = pos_q;
    neg_t   = neg_q;
    mag_t   = mag_q;
    point_t = point_q;
    frac_t  = frac_q;
    stop_t  = stop_q;
    bad_t   = bad_q;
    if (pos_q == '0) begin
      neg_t = (rx_byte_i == CHAR_MINUS);
    end else if (pos_q <= POS_LAST_TEXT) begin
      if ((rx_byte_i < CHAR_POINT) || (rx_byte_i > CHAR_NINE)) begin
        bad_t = 1'b1;
      end
      if (!stop_q) begin
        if (is_digit) begin
          if (!point_q) begin
            mag_t = MAG_W'(mag_q * 10) + int_digit(digit);
          end else if (int'(frac_q) < FRACTION_DIGITS) begin
            mag_t  = mag_q + frac_digit(digit, frac_q);
            frac_t = frac_q + 1'b1;
          end
        end else if ((rx_byte_i == CHAR_POINT) && !point_q) begin
          point_t = 1'b1;
        end else begin
          stop_t = 1'b1;
        end
      end
    end
    if (pos_q < POS_MAX) begin
      pos_t = pos_q + 1'b1;
    end
  end

  assign res_o.short_resp = (pos_t < RESPONSE_MIN_BYTES);
  assign res_o.bad_char   = bad_t;
  assign res_o.reading    = neg_t ? -$signed({1'b0, mag_t}) : $signed({1'b0, mag_t});

  always_comb begin
    pos_d   = pos_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    point_d = point_q;
    frac_d  = frac_q;
    stop_d  = stop_q;
    bad_d   = bad_q;
    if (step_i) begin
      case (cmd_e'(cmd_i))
        CMD_BYTE: begin
          if (eor_i) begin
            pos_d   = '0;
            neg_d   = 1'b0;
            mag_d   = '0;
            point_d = 1'b0;
            frac_d  = '0;
            stop_d  = 1'b0;
            bad_d   = 1'b0;
          end else begin
            pos_d   = pos_t;
            neg_d   = neg_t;
            mag_d   = mag_t;
            point_d = point_t;
            frac_d  = frac_t;
            stop_d  = stop_t;
            bad_d   = bad_t;
          end
        end
        CMD_TIMEOUT, CMD_RESTART: begin
          pos_d   = '0;
          neg_d   = 1'b0;
          mag_d   = '0;
          point_d = 1'b0;
          frac_d  = '0;
          stop_d  = 1'b0;
          bad_d   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      point_q <= 1'b0;
      frac_q  <= '0;
      stop_q  <= 1'b0;
      bad_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
      point_q <= point_d;
      frac_q  <= frac_d;
      stop_q  <= stop_d;
      bad_q   <= bad_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/swsd_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stability tracker
// Holds two recent readings with their timestamps and reports stability.
// ----------------------------------------------------------------------------
module swsd_tracker
  import swsd_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire logic                       clear_i,
  input  wire logic                       feed_i,
  input  wire logic signed [WEIGHT_W-1:0] weight_i,
  input  wire logic        [TIME_BITS-1:0] time_i,
  input  wire logic        [DUR_W-1:0]    duration_i,
  output logic                            stable_o,
  output logic signed      [WEIGHT_W-1:0] stable_weight_o
);

  logic                       primed_q, primed_d;
  logic signed [WEIGHT_W-1:0] held_w_q, held_w_d;
  logic        [TIME_BITS-1:0] held_t_q, held_t_d;
  logic signed [WEIGHT_W-1:0] cand_w_q, cand_w_d;
  logic        [TIME_BITS-1:0] cand_t_q, cand_t_d;
  logic        [TIME_BITS-1:0] held_age;
  logic        [TIME_BITS-1:0] cand_age;
  logic        [TIME_BITS-1:0] limit;

  assign held_age = time_i - held_t_q;
  assign cand_age = time_i - cand_t_q;
  assign limit    = TIME_BITS'(duration_i);

  always_comb begin
    primed_d        = primed_q;
    held_w_d        = held_w_q;
    held_t_d        = held_t_q;
    cand_w_d        = cand_w_q;
    cand_t_d        = cand_t_q;
    stable_o        = 1'b0;
    stable_weight_o = '0;
    if (clear_i) begin
      primed_d = 1'b0;
      held_w_d = '0;
      held_t_d = '0;
      cand_w_d = '0;
      cand_t_d = '0;
    end else if (feed_i) begin
      if (!primed_q) begin
        primed_d = 1'b1;
        held_w_d = weight_i;
        held_t_d = time_i;
        cand_w_d = weight_i;
        cand_t_d = time_i;
      end else if (weight_i != held_w_q) begin
        if (weight_i != cand_w_q) begin
          held_w_d = cand_w_q;
          held_t_d = cand_t_q;
          cand_w_d = weight_i;
          cand_t_d = time_i;
        end else if (cand_age > limit) begin
          stable_o        = 1'b1;
          stable_weight_o = cand_w_q;
        end
      end else if (held_age > limit) begin
        stable_o        = 1'b1;
        stable_weight_o = held_w_q;
      end
      if (stable_o) begin
        primed_d = 1'b0;
        held_w_d = '0;
        held_t_d = '0;
        cand_w_d = '0;
        cand_t_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
      held_w_q <= '0;
      held_t_q <= '0;
      cand_w_q <= '0;
      cand_t_q <= '0;
    end else if (step_i) begin
      primed_q <= primed_d;
      held_w_q <= held_w_d;
      held_t_q <= held_t_d;
      cand_w_q <= cand_w_d;
      cand_t_q <= cand_t_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/scale_weight_stability_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scale weight stability detector
// Parses scale response words and reports when the weight has settled.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_ready_o  cmd_i, rx_byte_i, end_of_response_i,
//                                               time_ms_i
// out       output     out_valid_o/out_ready_i  status_o, reading_milli_o,
//                                               stable_milli_o
// cfg       input      APB psel/penable, pready paddr, pwdata, prdata
//
// One word is accepted per cycle while the output is not stalled. A word is
// registered on acceptance and is processed once the output register is free
// or being taken, when any result it yields enters the output register. The
// output register frees its slot in the cycle it is taken, so back-to-back
// flow holds under out_ready_i. While a result waits with out_ready_i low, the
// input register keeps its word and in_ready_o falls. Reset clears the
// parser, the tracker and both valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module scale_weight_stability_detector
  import swsd_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [1:0]                 cmd_i,
  input  wire logic [7:0]                 rx_byte_i,
  input  wire logic                       end_of_response_i,
  input  wire logic [31:0]                time_ms_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [1:0]                      status_o,
  output logic signed [WEIGHT_W-1:0]      reading_milli_o,
  output logic signed [WEIGHT_W-1:0]      stable_milli_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [1:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic                       in_vld_q, in_vld_d;
  logic [1:0]                 cmd_q;
  logic [7:0]                 byte_q;
  logic                       eor_q;
  logic [31:0]                time_q;
  logic                       adv;
  logic                       in_acc;

  logic                       out_vld_q, out_vld_d;
  logic [1:0]                 status_q, status_d;
  logic signed [WEIGHT_W-1:0] reading_q, reading_d;
  logic signed [WEIGHT_W-1:0] stable_q, stable_d;

  logic [DUR_W-1:0]           duration;
  parse_res_t                 pres;
  logic                       produce;
  logic                       trk_clear;
  logic                       trk_feed;
  logic                       trk_stable;
  logic signed [WEIGHT_W-1:0] trk_weight;

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign in_acc     = in_valid_i && in_ready_o;

  swsd_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .duration_o (duration)
  );

  swsd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv),
    .cmd_i     (cmd_q),
    .rx_byte_i (byte_q),
    .eor_i     (eor_q),
    .res_o     (pres)
  );

  always_comb begin
    produce   = 1'b0;
    trk_clear = 1'b0;
    trk_feed  = 1'b0;
    status_d  = ST_WAIT;
    reading_d = '0;
    stable_d  = '0;
    case (cmd_e'(cmd_q))
      CMD_BYTE: begin
        if (eor_q) begin
          produce = 1'b1;
          if (pres.short_resp) begin
            status_d  = ST_TIMEOUT;
            trk_clear = 1'b1;
          end else if (pres.bad_char) begin
            status_d  = ST_BADCHAR;
            trk_clear = 1'b1;
          end else begin
            trk_feed  = 1'b1;
            reading_d = pres.reading;
            status_d  = trk_stable ? ST_STABLE : ST_WAIT;
            stable_d  = trk_weight;
          end
        end
      end
      CMD_TIMEOUT: begin
        produce   = 1'b1;
        status_d  = ST_TIMEOUT;
        trk_clear = 1'b1;
      end
      CMD_RESTART: begin
        trk_clear = 1'b1;
      end
      default: begin
      end
    endcase
  end

  swsd_tracker #(
    .TIME_BITS (TIME_BITS)
  ) u_tracker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (adv),
    .clear_i         (trk_clear),
    .feed_i          (trk_feed),
    .weight_i        (pres.reading),
    .time_i          (time_q[TIME_BITS-1:0]),
    .duration_i      (duration),
    .stable_o        (trk_stable),
    .stable_weight_o (trk_weight)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = produce;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= cmd_i;
      byte_q <= rx_byte_i;
      eor_q  <= end_of_response_i;
      time_q <= time_ms_i;
    end
    if (adv && produce) begin
      status_q  <= status_d;
      reading_q <= reading_d;
      stable_q  <= stable_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = status_q;
  assign reading_milli_o = reading_q;
  assign stable_milli_o  = stable_q;

endmodule
`default_nettype wire

// ===== sv/swsd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Port checker
// Watches the result channel of the detector for consistent words.
// ----------------------------------------------------------------------------
module swsd_sva
  import swsd_pkg::*;
(
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [1:0]                 status_o,
  input wire logic signed [WEIGHT_W-1:0] reading_milli_o,
  input wire logic signed [WEIGHT_W-1:0] stable_milli_o
);

  // A stalled result word stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(reading_milli_o) && $stable(stable_milli_o))
    else $error("result word changed while stalled");

  // The settled weight is only reported with a stable status.
  a_stable_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_STABLE) |-> stable_milli_o == '0)
    else $error("settled weight reported without stable status");

  // Errors carry no reading.
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == ST_TIMEOUT) || (status_o == ST_BADCHAR))
      |-> reading_milli_o == '0)
    else $error("reading reported with an error status");

  // A stable weight is the reading that confirmed it.
  a_stable_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_STABLE) |-> stable_milli_o == reading_milli_o)
    else $error("settled weight differs from its reading");

endmodule

bind scale_weight_stability_detector swsd_sva u_swsd_sva (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .reading_milli_o (reading_milli_o),
  .stable_milli_o  (stable_milli_o)
);
`default_nettype wire
